// File: hdl/crc32_frame_receiver_unit_defines.svh
// assertion macros for the crc32 frame receiver
// used by crc32_frame_receiver_unit.sv, expects signals clock and reset in scope
`ifndef CRC32_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRC32_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CFR_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/cfr_pkg.sv
// shared types, constants and the byte-wide crc-32 update for the frame receiver
// no dependencies
package cfr_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ALL  = 32'hFFFFFFFF;

   localparam int unsigned HDR_BYTES = 8;
   localparam int unsigned CRC_BYTES = 4;

   localparam logic [15:0] MAX_PAYLOAD_RST   = 16'(16 * 1024);
   localparam logic [8:0]  CHANNEL_COUNT_RST = 9'd8;

   // csr register indexes
   localparam logic CSR_MAX_PAYLOAD   = 1'b0;
   localparam logic CSR_CHANNEL_COUNT = 1'b1;

   // result kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict codes
   localparam logic [1:0] VERDICT_GOOD    = 2'd0;
   localparam logic [1:0] VERDICT_BAD_HDR = 2'd1;
   localparam logic [1:0] VERDICT_BAD_CRC = 2'd2;

   localparam int unsigned RSP_DATA_W = 184;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_CRC     = 2'd2
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  channel;
      logic [15:0] frame_flags;
      logic [15:0] payload_len;
      logic [1:0]  verdict;
      logic [31:0] error_total;
      logic [31:0] good_frames;
      logic [63:0] good_bytes;
   } rsp_type;

   // reflected crc-32, one byte, lsb first
   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: hdl/crc32_frame_receiver_unit.sv
// crc-32 checked frame receiver: header parse, payload pass-through, crc check, counters
// depends on cfr_pkg and crc32_frame_receiver_unit_defines.svh
`include "crc32_frame_receiver_unit_defines.svh"

// channel  dir  fields
// req_     in   tdata[7:0] rx_byte
// rsp_     out  tuser[0] kind; tdata data_byte .. good_bytes (see port list)
// csr_     in   index 0 max_payload, index 1 channel_count
//
// one byte per cycle: each word is parsed on accept, header and payload words crc-folded,
// the longest path being the eight-step byte-wide crc update and the 64-bit byte counter
// the result lands in an output register backed by one skid entry, so req_tready only
// drops while both are full and a stalled rsp side costs no input cycle until then
// reset is synchronous and restores the register defaults, the counters and header hunt
module crc32_frame_receiver_unit
   import cfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [15:8] channel,
                                              // [31:16] frame_flags, [47:32] payload_len,
                                              // [49:48] verdict, [81:50] error_total,
                                              // [113:82] good_frames, [177:114] good_bytes,
                                              // [183:178] zero
   output logic [0:0]            rsp_tuser,   // [0] kind
   // register writes
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   // config registers
   logic [15:0] max_payload_ff;
   logic [8:0]  channel_count_ff;

   // frame state
   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [7:0]  chan_ff, chan_in;
   logic [15:0] flags_ff, flags_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [31:0] crc_run_ff, crc_run_in;
   logic [23:0] crc_rx_ff, crc_rx_in;     // low three bytes of the received crc
   logic [31:0] err_count_ff, err_count_in;
   logic [31:0] frame_count_ff, frame_count_in;
   logic [63:0] byte_count_ff, byte_count_in;

   // output register and skid entry
   logic        out_valid_ff;
   rsp_type     out_ff;
   logic        skid_valid_ff;
   rsp_type     skid_ff;

   logic        accept;
   logic [7:0]  b;
   logic [2:0]  hdr_idx;
   logic        hdr_last;
   logic        hdr_bad;
   logic [15:0] len_full;
   logic [15:0] rem_dec;
   logic        crc_last;
   logic        crc_ok;
   logic [31:0] crc_base;
   logic        has_result;
   rsp_type     result;

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign b          = req_tdata;

   // an unused phase code restarts the header at its first byte
   assign hdr_idx  = (phase_ff == PH_HEADER) ? byte_index_ff : 3'd0;
   assign hdr_last = (hdr_idx == 3'd7);
   assign len_full = {b, len_ff[7:0]};
   assign hdr_bad  = (len_full > max_payload_ff) || ({1'b0, chan_ff} >= channel_count_ff);
   assign rem_dec  = remaining_ff - 16'd1;
   assign crc_last = (byte_index_ff == 3'd3);
   assign crc_ok   = ((crc_run_ff ^ CRC_ALL) == {b, crc_rx_ff});
   assign crc_base = (hdr_idx == 3'd0) ? CRC_ALL : crc_run_ff;

   // next phase and byte position
   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      if (accept) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               if (rem_dec == 16'd0) begin
                  phase_in      = PH_CRC;
                  byte_index_in = 3'd0;
               end
            end
            PH_CRC: begin
               if (crc_last) begin
                  phase_in      = PH_HEADER;
                  byte_index_in = 3'd0;
               end else begin
                  byte_index_in = byte_index_ff + 3'd1;
               end
            end
            default: begin
               phase_in      = PH_HEADER;
               byte_index_in = hdr_idx + 3'd1;   // wraps to zero after the last header byte
               if (hdr_last && !hdr_bad) begin
                  phase_in = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
               end
            end
         endcase
      end
   end

   // datapath, counters and result word
   always_comb begin
      chan_in        = chan_ff;
      flags_in       = flags_ff;
      len_in         = len_ff;
      remaining_in   = remaining_ff;
      crc_run_in     = crc_run_ff;
      crc_rx_in      = crc_rx_ff;
      err_count_in   = err_count_ff;
      frame_count_in = frame_count_ff;
      byte_count_in  = byte_count_ff;
      has_result     = 1'b0;
      result.kind    = KIND_DATA;
      result.data_byte = 8'd0;
      result.verdict = VERDICT_GOOD;
      if (accept) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               crc_run_in       = crc_step(crc_run_ff, b);
               remaining_in     = rem_dec;
               has_result       = 1'b1;
               result.data_byte = b;
            end
            PH_CRC: begin
               case (byte_index_ff[1:0])
                  2'd0:    crc_rx_in[7:0]   = b;
                  2'd1:    crc_rx_in[15:8]  = b;
                  2'd2:    crc_rx_in[23:16] = b;
                  default: crc_rx_in        = crc_rx_ff;
               endcase
               if (crc_last) begin
                  has_result  = 1'b1;
                  result.kind = KIND_VERDICT;
                  crc_run_in  = CRC_ALL;
                  if (crc_ok) begin
                     frame_count_in = frame_count_ff + 32'd1;
                     byte_count_in  = byte_count_ff + 64'(len_ff)
                                      + 64'(HDR_BYTES + CRC_BYTES);
                  end else begin
                     err_count_in   = err_count_ff + 32'd1;
                     result.verdict = VERDICT_BAD_CRC;
                  end
               end
            end
            default: begin
               crc_run_in = crc_step(crc_base, b);
               case (hdr_idx)
                  3'd0:    chan_in         = b;
                  3'd4:    flags_in        = {8'd0, b};
                  3'd5:    flags_in[15:8]  = b;
                  3'd6:    len_in          = {8'd0, b};
                  3'd7:    len_in          = len_full;
                  default: chan_in         = chan_ff;
               endcase
               if (hdr_last) begin
                  if (hdr_bad) begin
                     err_count_in   = err_count_ff + 32'd1;
                     crc_run_in     = CRC_ALL;
                     has_result     = 1'b1;
                     result.kind    = KIND_VERDICT;
                     result.verdict = VERDICT_BAD_HDR;
                  end else begin
                     remaining_in = len_full;
                  end
               end
            end
         endcase
      end
      result.channel     = chan_in;
      result.frame_flags = flags_in;
      result.payload_len = len_in;
      result.error_total = err_count_in;
      result.good_frames = frame_count_in;
      result.good_bytes  = byte_count_in;
   end

   // config port
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff   <= MAX_PAYLOAD_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_PAYLOAD:   max_payload_ff   <= csr_wdata;
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[8:0];
            default:           max_payload_ff   <= max_payload_ff;
         endcase
      end
   end

   // frame state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         byte_index_ff  <= 3'd0;
         chan_ff        <= 8'd0;
         flags_ff       <= 16'd0;
         len_ff         <= 16'd0;
         remaining_ff   <= 16'd0;
         crc_run_ff     <= CRC_ALL;
         err_count_ff   <= 32'd0;
         frame_count_ff <= 32'd0;
         byte_count_ff  <= 64'd0;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         chan_ff        <= chan_in;
         flags_ff       <= flags_in;
         len_ff         <= len_in;
         remaining_ff   <= remaining_in;
         crc_run_ff     <= crc_run_in;
         err_count_ff   <= err_count_in;
         frame_count_ff <= frame_count_in;
         byte_count_ff  <= byte_count_in;
      end
   end

   // received crc bytes, each written before it is read
   always_ff @(posedge clock) begin
      crc_rx_ff <= crc_rx_in;
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_tready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= has_result;
         end
      end else if (has_result) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tready || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (has_result) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tuser[0] = out_ff.kind;
   assign rsp_tdata    = {6'd0, out_ff.good_bytes, out_ff.good_frames, out_ff.error_total,
                          out_ff.verdict, out_ff.payload_len, out_ff.frame_flags,
                          out_ff.channel, out_ff.data_byte};

   `CFR_ASSERT_IMPLIES(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full with output empty")
   `CFR_ASSERT_IMPLIES(a_verdict_no_data, out_valid_ff && (out_ff.kind == KIND_VERDICT), out_ff.data_byte == 8'd0, "verdict word carries data")
   `CFR_ASSERT_IMPLIES(a_data_no_verdict, out_valid_ff && (out_ff.kind == KIND_DATA), out_ff.verdict == VERDICT_GOOD, "payload word carries verdict")
   `CFR_ASSERT_IMPLIES(a_payload_left, phase_ff == PH_PAYLOAD, remaining_ff != 16'd0, "payload phase with nothing left")
   `CFR_ASSERT_NEXT(a_crc_position, phase_ff == PH_CRC, byte_index_ff[2] == 1'b0 || phase_ff != PH_CRC, "crc byte index out of range")

endmodule
